/* src/adc_pedestal_gain_match_top_assert.svh */
// ---------------------------------------------------------------------------
// adc_pedestal_gain_match_top_assert.svh
// Assertion macros used by the checker file apg_checker.sv.
// ---------------------------------------------------------------------------
`ifndef ADC_PEDESTAL_GAIN_MATCH_TOP_ASSERT_SVH
`define ADC_PEDESTAL_GAIN_MATCH_TOP_ASSERT_SVH

// Clocked assertion, switched off while reset is held
`define APG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset
`define APG_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/apg_pkg.sv */
// ---------------------------------------------------------------------------
// apg_pkg
// Types, sizes and constants of the pedestal and gain-match pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package apg_pkg;

  // Table geometry
  localparam int NUM_SECTORS         = 6;
  localparam int COUNTERS_PER_SECTOR = 57;
  localparam int ADC_BITS            = 13;
  localparam int TABLE_DEPTH         = NUM_SECTORS * COUNTERS_PER_SECTOR;
  localparam int ADDR_W              = $clog2(TABLE_DEPTH);

  // Fixed port field widths
  localparam int SECTOR_W  = 3;
  localparam int COUNTER_W = 8;
  localparam int FIELD_W   = 13;
  localparam int GEO_W     = 17;
  localparam int LOG_OUT_W = 16;
  localparam int STATUS_W  = 2;

  // log2 in fixed point: msb position plus LOG_FRAC fraction bits
  localparam int LOG_FRAC = 28;
  localparam int EXP_W    = $clog2(ADC_BITS);
  localparam int LOG_W    = EXP_W + LOG_FRAC;
  localparam int MANT_W   = 32;

  // Square root of 1024*L*R: 4 fraction bits doubled, plus one rounding bit
  localparam int SQ_PAD   = 10;
  localparam int SQ_W     = 2 * ADC_BITS + SQ_PAD;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int ROOT_W   = SQ_STEPS;
  localparam logic [GEO_W-1:0] GEO_MAX = '1;

  // ln2 scaling and rounding of the log difference
  localparam logic [31:0] LN2_Q32  = 32'hB17217F8;
  localparam int          PROD_W    = LOG_W + 32;
  localparam int          RND_SHIFT = 49;

  // Pipeline stage positions
  localparam int ST_IN   = 0;
  localparam int ST_NET  = 1;
  localparam int ST_LOG0 = 2;
  localparam int ST_CMP  = ST_LOG0 + LOG_FRAC + 1;
  localparam int ST_MUL  = ST_CMP + 1;
  localparam int ST_OUT  = ST_MUL + 1;
  localparam int NSTG    = ST_OUT + 1;

  // Item kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_HIT  = 1'b1;

  // Log status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'b00;
  localparam logic [STATUS_W-1:0] STATUS_LEFT_ZERO  = 2'b01;
  localparam logic [STATUS_W-1:0] STATUS_RIGHT_ZERO = 2'b10;

  typedef struct packed {
    logic                 func;
    logic [SECTOR_W-1:0]  sector;
    logic [COUNTER_W-1:0] counter;
    logic [FIELD_W-1:0]   adc_left;
    logic [FIELD_W-1:0]   adc_right;
    logic [FIELD_W-1:0]   ped_left;
    logic [FIELD_W-1:0]   ped_right;
  } in_item_t;

  typedef struct packed {
    logic [SECTOR_W-1:0]         out_sector;
    logic [COUNTER_W-1:0]        out_counter;
    logic [FIELD_W-1:0]          net_left;
    logic [FIELD_W-1:0]          net_right;
    logic [GEO_W-1:0]            geo_mean;
    logic signed [LOG_OUT_W-1:0] log_ratio;
    logic [STATUS_W-1:0]         log_status;
    logic                        index_error;
  } out_item_t;

  // Per-hit data that rides along the pipeline
  typedef struct packed {
    logic [SECTOR_W-1:0]  sector;
    logic [COUNTER_W-1:0] counter;
    logic [ADC_BITS-1:0]  nl;
    logic [ADC_BITS-1:0]  nr;
    logic [STATUS_W-1:0]  status;
    logic                 bad;
  } meta_t;

endpackage

`default_nettype wire

/* src/apg_if.sv */
// ---------------------------------------------------------------------------
// apg_if
// Valid/ready channels for hit and load items and for results.
// ---------------------------------------------------------------------------
`default_nettype none

interface apg_in_if;
  import apg_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface apg_out_if;
  import apg_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/apg_ram.sv */
// ---------------------------------------------------------------------------
// apg_ram
// Generic one-write one-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module apg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/apg_log2.sv */
// ---------------------------------------------------------------------------
// apg_log2
// Pipelined log2 in fixed point: msb search, then one squaring per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module apg_log2 (
  input  logic                         clk,
  input  logic [apg_pkg::LOG_FRAC:0]   en,
  input  logic [apg_pkg::ADC_BITS-1:0] x,
  output logic [apg_pkg::LOG_W-1:0]    log_val
);
  import apg_pkg::*;

  logic [EXP_W-1:0]    exp_r  [0:LOG_FRAC];
  logic [MANT_W-1:0]   mant_r [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] frac_r [1:LOG_FRAC];

  logic [EXP_W-1:0]  msb;
  logic [MANT_W-1:0] mant0;

  // Find the msb position and normalize the mantissa to Q1.31
  always_comb begin
    msb = '0;
    for (int i = 0; i < ADC_BITS; i++) begin
      if (x[i]) begin
        msb = EXP_W'(i);
      end
    end
    mant0 = MANT_W'(x) << (MANT_W - 1 - int'(msb));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      exp_r[0]  <= msb;
      mant_r[0] <= mant0;
    end
  end

  // Square, take one fraction bit, renormalize
  for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    logic                fbit;
    logic [MANT_W-1:0]   mant_nxt;

    always_comb begin
      sq       = mant_r[j-1] * mant_r[j-1];
      t        = sq[2*MANT_W-1:MANT_W-1];
      fbit     = t[MANT_W];
      mant_nxt = fbit ? t[MANT_W:1] : t[MANT_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        exp_r[j]  <= exp_r[j-1];
        mant_r[j] <= mant_nxt;
      end
    end

    if (j == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en[j]) begin
          frac_r[j] <= LOG_FRAC'(fbit);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[j]) begin
          frac_r[j] <= {frac_r[j-1][LOG_FRAC-2:0], fbit};
        end
      end
    end
  end

  assign log_val = {exp_r[LOG_FRAC], frac_r[LOG_FRAC]};

endmodule

`default_nettype wire

/* src/adc_pedestal_gain_match_top.sv */
// ---------------------------------------------------------------------------
// adc_pedestal_gain_match_top
// Pedestal subtraction, geometric mean and log ratio of scintillator hits.
// ---------------------------------------------------------------------------
// Usage:
//   in_if carries load items (func 0: store a pedestal pair for a
//   sector/counter) and hit items (func 1). out_if carries one result per
//   hit; loads give none. Both channels transfer on valid and ready high.
//   There are 34 register stages: input, pedestal, the msb stage and 28
//   squaring stages of the log2 units, compare, ln2 multiply and output.
//   Throughput: one item per cycle while out_if is ready or a stage is
//   empty. A load takes effect for any hit transferred in a later cycle.
//   Reset clears all stage valid bits; the pedestal tables are not cleared
//   and hold undefined data until loaded.
//   When the receiver stalls, the output register holds its result and
//   each stage behind an empty slot moves up, so in_if stays ready
//   until every stage holds a hit.
// ---------------------------------------------------------------------------
`default_nettype none

module adc_pedestal_gain_match_top (
  input  logic      clk,
  input  logic      rst_n,
  apg_in_if.sink    in_if,
  apg_out_if.source out_if
);
  import apg_pkg::*;

  logic [NSTG-1:0] en;
  logic [NSTG-1:0] v_r, v_nxt;

  // A stage may load when the output is ready or when it or any stage ahead of it is empty
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = out_if.ready | ~(&v_r[NSTG-1:k]);
  end

  assign in_if.ready = en[ST_IN];

  // Advance valid bits
  always_comb begin
    v_nxt = v_r;
    if (en[ST_IN]) begin
      v_nxt[ST_IN] = in_if.valid && (in_if.data.func == FUNC_HIT);
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Decode the table index
  in_item_t            in_d;
  logic                idx_ok, in_xfer, tbl_we;
  logic [ADDR_W-1:0]   idx;
  logic [2*ADC_BITS-1:0] tbl_wdata, tbl_rdata;

  assign in_d    = in_if.data;
  assign in_xfer = in_if.valid && en[ST_IN];

  always_comb begin
    idx_ok = (int'(in_d.sector) >= 1) && (int'(in_d.sector) <= NUM_SECTORS) &&
             (int'(in_d.counter) >= 1) && (int'(in_d.counter) <= COUNTERS_PER_SECTOR);
    idx    = ADDR_W'((int'(in_d.sector) - 1) * COUNTERS_PER_SECTOR +
                     int'(in_d.counter) - 1);
  end

  assign tbl_we    = in_xfer && (in_d.func == FUNC_LOAD) && idx_ok;
  assign tbl_wdata = {ADC_BITS'(in_d.ped_left), ADC_BITS'(in_d.ped_right)};

  apg_ram #(
    .WIDTH (2 * ADC_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_ped_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (idx),
    .wdata (tbl_wdata),
    .re    (en[ST_IN]),
    .raddr (idx),
    .rdata (tbl_rdata)
  );

  // Input stage: capture the hit next to the table read
  logic [SECTOR_W-1:0]  s0_sector_r;
  logic [COUNTER_W-1:0] s0_counter_r;
  logic                 s0_bad_r;
  logic [ADC_BITS-1:0]  s0_adcl_r, s0_adcr_r;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      s0_sector_r  <= in_d.sector;
      s0_counter_r <= in_d.counter;
      s0_bad_r     <= !idx_ok;
      s0_adcl_r    <= ADC_BITS'(in_d.adc_left);
      s0_adcr_r    <= ADC_BITS'(in_d.adc_right);
    end
  end

  // Net stage: subtract pedestals, clamp, flag zero sides
  meta_t               meta_r [ST_NET:ST_MUL];
  meta_t               m1_nxt;
  logic [ADC_BITS-1:0] ped_l, ped_r;

  assign ped_l = tbl_rdata[2*ADC_BITS-1:ADC_BITS];
  assign ped_r = tbl_rdata[ADC_BITS-1:0];

  always_comb begin
    m1_nxt.sector  = s0_sector_r;
    m1_nxt.counter = s0_counter_r;
    m1_nxt.bad     = s0_bad_r;
    m1_nxt.nl      = (s0_adcl_r > ped_l) ? s0_adcl_r - ped_l : '0;
    m1_nxt.nr      = (s0_adcr_r > ped_r) ? s0_adcr_r - ped_r : '0;
    if (s0_bad_r) begin
      m1_nxt.nl = '0;
      m1_nxt.nr = '0;
    end
    m1_nxt.status = STATUS_OK;
    if (!s0_bad_r && (m1_nxt.nl == '0)) begin
      m1_nxt.status = m1_nxt.status | STATUS_LEFT_ZERO;
    end
    if (!s0_bad_r && (m1_nxt.nr == '0)) begin
      m1_nxt.status = m1_nxt.status | STATUS_RIGHT_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_NET]) begin
      meta_r[ST_NET] <= m1_nxt;
    end
  end

  // Carry hit data along the rest of the pipeline
  for (genvar k = ST_NET + 1; k <= ST_MUL; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (en[k]) begin
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  // Log2 of both sides
  logic [LOG_W-1:0] log_l, log_r;

  apg_log2 u_log_left (
    .clk     (clk),
    .en      (en[ST_LOG0 +: LOG_FRAC + 1]),
    .x       (meta_r[ST_NET].nl),
    .log_val (log_l)
  );

  apg_log2 u_log_right (
    .clk     (clk),
    .en      (en[ST_LOG0 +: LOG_FRAC + 1]),
    .x       (meta_r[ST_NET].nr),
    .log_val (log_r)
  );

  // Square root of 1024*L*R, one result bit per stage
  logic [SQ_W-1:0]   rem_r [0:SQ_STEPS-1];
  logic [SQ_W-1:0]   res_r [0:SQ_STEPS];
  logic [ROOT_W-1:0] root_r [SQ_STEPS+1:LOG_FRAC];

  always_ff @(posedge clk) begin
    if (en[ST_LOG0]) begin
      rem_r[0] <= {(2*ADC_BITS)'(meta_r[ST_NET].nl) * (2*ADC_BITS)'(meta_r[ST_NET].nr),
                   SQ_PAD'(0)};
      res_r[0] <= '0;
    end
  end

  for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 * j);
    logic [SQ_W:0]   trial;
    logic [SQ_W-1:0] rem_nxt, res_nxt;

    always_comb begin
      trial = {1'b0, res_r[j-1]} + {1'b0, BIT};
      if ({1'b0, rem_r[j-1]} >= trial) begin
        rem_nxt = rem_r[j-1] - trial[SQ_W-1:0];
        res_nxt = (res_r[j-1] >> 1) + BIT;
      end else begin
        rem_nxt = rem_r[j-1];
        res_nxt = res_r[j-1] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_LOG0 + j]) begin
        res_r[j] <= res_nxt;
      end
    end

    if (j < SQ_STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[ST_LOG0 + j]) begin
          rem_r[j] <= rem_nxt;
        end
      end
    end
  end

  // Hold the root until the log units finish
  for (genvar j = SQ_STEPS + 1; j <= LOG_FRAC; j++) begin : g_root
    if (j == SQ_STEPS + 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en[ST_LOG0 + j]) begin
          root_r[j] <= res_r[SQ_STEPS][ROOT_W-1:0];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en[ST_LOG0 + j]) begin
          root_r[j] <= root_r[j-1];
        end
      end
    end
  end

  // Compare stage: log difference sign and magnitude, rounded and clamped mean
  logic             neg_r, neg2_r;
  logic [LOG_W-1:0] d_r, d_nxt;
  logic [GEO_W-1:0] geo_r, geo2_r, geo_nxt;
  logic [ROOT_W:0]  root_inc;
  logic [ROOT_W-1:0] root_half;

  always_comb begin
    d_nxt     = (log_r < log_l) ? log_l - log_r : log_r - log_l;
    root_inc  = {1'b0, root_r[LOG_FRAC]} + (ROOT_W + 1)'(1);
    root_half = root_inc[ROOT_W:1];
    geo_nxt   = (32'(root_half) > 32'(GEO_MAX)) ? GEO_MAX : GEO_W'(root_half);
  end

  always_ff @(posedge clk) begin
    if (en[ST_CMP]) begin
      neg_r <= (log_r < log_l);
      d_r   <= d_nxt;
      geo_r <= geo_nxt;
    end
  end

  // Multiply stage: scale by ln2
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      prod_r <= d_r * LN2_Q32;
      neg2_r <= neg_r;
      geo2_r <= geo_r;
    end
  end

  // Output stage: round half away from zero, apply sign, zero the ratio on a zero side or bad index
  out_item_t             out_r, out_nxt;
  logic [PROD_W-1:0]     rnd_sum;
  logic [LOG_OUT_W-1:0]  mag;
  meta_t                 mo;

  always_comb begin
    mo      = meta_r[ST_MUL];
    rnd_sum = prod_r + (PROD_W'(1) << (RND_SHIFT - 1));
    mag     = LOG_OUT_W'(rnd_sum >> RND_SHIFT);
    out_nxt.out_sector  = mo.sector;
    out_nxt.out_counter = mo.counter;
    out_nxt.net_left    = FIELD_W'(mo.nl);
    out_nxt.net_right   = FIELD_W'(mo.nr);
    out_nxt.geo_mean    = geo2_r;
    out_nxt.log_status  = mo.status;
    out_nxt.index_error = mo.bad;
    if (mo.bad || (mo.status != STATUS_OK)) begin
      out_nxt.log_ratio = '0;
    end else if (neg2_r) begin
      out_nxt.log_ratio = -mag;
    end else begin
      out_nxt.log_ratio = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid = v_r[ST_OUT];
  assign out_if.data  = out_r;

endmodule

`default_nettype wire

/* src/apg_checker.sv */
// ---------------------------------------------------------------------------
// apg_checker
// Port-level checks of the pedestal and gain-match pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module apg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input apg_pkg::out_item_t out_data
);
  import apg_pkg::*;

  `include "adc_pedestal_gain_match_top_assert.svh"

  // No result right after reset
  `APG_ASSERT_ANY(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // A draining output never blocks the input side
  `APG_ASSERT(a_ready_flow, out_ready |-> in_ready, "input stalled while output drains")

  // Stalled result holds
  `APG_ASSERT(a_stall_hold,
              out_valid && !out_ready |=> out_valid && $stable(out_data),
              "stalled result changed")

  // Zero side or bad index gives no log ratio
  `APG_ASSERT(a_log_zero,
              out_valid && (out_data.index_error || out_data.log_status != STATUS_OK)
                |-> out_data.log_ratio == '0,
              "log ratio set on flagged hit")

endmodule

bind adc_pedestal_gain_match_top apg_checker u_apg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

`default_nettype wire
